FILE: sv/krt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyed range table with smoothing.
// Used by keyed_range_table_with_smoothing; depends on nothing else.
package krt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int OPCODE_W = 2;
    localparam int ADDR_W = 16;
    localparam int RANGE_W = 32;
    localparam int LEVEL_W = 16;
    localparam int TIME_W = 32;
    localparam int STATUS_W = 2;
    localparam int ENTRY_COUNT_W = 5;
    localparam int LIMIT_W = 16;

    localparam int SUM_W = RANGE_W + 2;
    localparam int DIV_STEPS = 7;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [DIV_CNT_W-1:0] DSTEP_SEED   = 3'd0;
    localparam logic [DIV_CNT_W-1:0] DSTEP_FOLD4  = 3'd1;
    localparam logic [DIV_CNT_W-1:0] DSTEP_FOLD8  = 3'd2;
    localparam logic [DIV_CNT_W-1:0] DSTEP_FOLD16 = 3'd3;
    localparam logic [DIV_CNT_W-1:0] DSTEP_TRIPLE = 3'd4;
    localparam logic [DIV_CNT_W-1:0] DSTEP_REM    = 3'd5;
    localparam logic [DIV_CNT_W-1:0] DSTEP_FIX    = 3'd6;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_STALE_LIMIT = '0;
    localparam logic [LIMIT_W-1:0] STALE_LIMIT_RESET = 16'd1000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD     = 2'd0,
        OP_REFRESH = 2'd1,
        OP_DELETE  = 2'd2,
        OP_QUERY   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_PREP,
        S_SUM,
        S_ABS,
        S_DIV,
        S_WRB,
        S_DEL
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [RANGE_W-1:0] newest;
        logic [RANGE_W-1:0] middle;
        logic [RANGE_W-1:0] oldest;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  last_seen;
    } t_entry;

endpackage

FILE: sv/keyed_range_table_with_smoothing.sv
`timescale 1ns / 1ps
// Top level of the keyed range table with smoothing: sequencer, entry memory,
// shared-adder divide-by-three sequence and configuration port. Depends on krt_pkg.
//
// A request is taken when start is high and busy is low; its single result
// appears on the o_ ports for one cycle with o_valid, and must be captured
// then. An add, or any request with address zero, is answered from the
// dispatch state without a scan. A lookup walks the entry memory one entry
// per cycle through its single read port, so a query ends at the matching
// entry, and a miss ends after all count entries have been read. A delete then
// moves each later entry up by one, or only lowers the count when it removes
// the last entry. A refresh passes through the stale check, the sum, the sign
// split, seven steps of the divide by three on one shared adder, and the write.
module keyed_range_table_with_smoothing (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [krt_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [krt_pkg::ADDR_W-1:0]        i_partner_address,
    input  logic signed [krt_pkg::RANGE_W-1:0] i_range_sample,
    input  logic signed [krt_pkg::LEVEL_W-1:0] i_signal_level,
    input  logic [krt_pkg::TIME_W-1:0]        i_now_ms,
    output logic                              o_valid,
    output logic [krt_pkg::STATUS_W-1:0]      o_status,
    output logic [krt_pkg::ENTRY_COUNT_W-1:0] o_entry_count,
    output logic signed [krt_pkg::RANGE_W-1:0] o_range_average,
    output logic signed [krt_pkg::LEVEL_W-1:0] o_signal_out,
    output logic                              o_history_cleared,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [krt_pkg::PADDR_W-1:0]       paddr,
    input  logic [krt_pkg::PDATA_W-1:0]       pwdata,
    output logic [krt_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import krt_pkg::*;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0] r_k, n_k;
    t_entry r_ent, n_ent;

    t_opcode r_op, n_op;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [RANGE_W-1:0] r_sample, n_sample;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [TIME_W-1:0] r_now, n_now;

    logic r_stale, n_stale;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SUM_W-1:0] r_mag, n_mag;
    logic [SUM_W-1:0] r_acc, n_acc;
    logic r_neg, n_neg;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    logic r_valid, n_valid;
    t_status r_status, n_status;
    logic [ENTRY_COUNT_W-1:0] r_out_count, n_out_count;
    logic [RANGE_W-1:0] r_avg, n_avg;
    logic [LEVEL_W-1:0] r_sig, n_sig;
    logic r_clr, n_clr;

    logic [LIMIT_W-1:0] r_limit;

    logic [IDX_W-1:0] rd_addr;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry mem_wdata;

    logic [CNT_W-1:0] idx_plus;
    logic match;
    logic [RANGE_W-1:0] kept_mid, kept_old, quot;
    logic [SUM_W-1:0] alu_a, alu_b, alu_res;
    logic alu_sub;
    logic [3:0] div_fix;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_STALE_LIMIT) ?
                    PDATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= STALE_LIMIT_RESET;
        end else if (cfg_write && paddr[PADDR_W-1:2] == REG_STALE_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign idx_plus = r_idx + CNT_W'(1);
    assign match = r_pend && (r_rd_data.address == r_addr);
    assign kept_mid = r_stale ? '0 : r_ent.newest;
    assign kept_old = r_stale ? '0 : r_ent.middle;
    assign quot = r_neg ? (RANGE_W'(0) - r_acc[RANGE_W-1:0]) : r_acc[RANGE_W-1:0];

    // Division by three: the sum of shifted copies approaches n/3 from below
    // within a few units, so the remainder left stays below 32 and a small
    // constant multiply gives the last correction.
    assign div_fix = 4'((10'(r_sum[4:0]) * 10'd11) >> 5);
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    always_comb begin
        alu_a   = r_acc;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_div_cnt)
            DSTEP_SEED: begin
                alu_a = r_mag >> 2;
                alu_b = r_mag >> 4;
            end
            DSTEP_FOLD4: begin
                alu_b = r_acc >> 4;
            end
            DSTEP_FOLD8: begin
                alu_b = r_acc >> 8;
            end
            DSTEP_FOLD16: begin
                alu_b = r_acc >> 16;
            end
            DSTEP_TRIPLE: begin
                alu_b = r_acc << 1;
            end
            DSTEP_REM: begin
                alu_a   = r_mag;
                alu_b   = r_sum;
                alu_sub = 1'b1;
            end
            default: begin
                alu_b = SUM_W'(div_fix);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_k         <= n_k;
        r_ent       <= n_ent;
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_sample    <= n_sample;
        r_level     <= n_level;
        r_now       <= n_now;
        r_stale     <= n_stale;
        r_sum       <= n_sum;
        r_mag       <= n_mag;
        r_acc       <= n_acc;
        r_neg       <= n_neg;
        r_div_cnt   <= n_div_cnt;
        r_status    <= n_status;
        r_out_count <= n_out_count;
        r_avg       <= n_avg;
        r_sig       <= n_sig;
        r_clr       <= n_clr;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_k         = r_k;
        n_ent       = r_ent;
        n_op        = r_op;
        n_addr      = r_addr;
        n_sample    = r_sample;
        n_level     = r_level;
        n_now       = r_now;
        n_stale     = r_stale;
        n_sum       = r_sum;
        n_mag       = r_mag;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_div_cnt   = r_div_cnt;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_out_count = r_out_count;
        n_avg       = r_avg;
        n_sig       = r_sig;
        n_clr       = r_clr;
        rd_addr     = r_idx[IDX_W-1:0];
        mem_we      = 1'b0;
        mem_waddr   = r_k;
        mem_wdata   = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = t_opcode'(i_opcode);
                    n_addr   = i_partner_address;
                    n_sample = i_range_sample;
                    n_level  = i_signal_level;
                    n_now    = i_now_ms;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_avg = '0;
                n_sig = '0;
                n_clr = 1'b0;
                if (r_op == OP_ADD) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                        n_status = STS_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IDX_W-1:0];
                        mem_wdata = '{address: r_addr, newest: '0, middle: '0,
                                      oldest: '0, level: '0, last_seen: r_now};
                        n_count   = r_count + CNT_W'(1);
                        n_status  = STS_OK;
                    end
                    n_out_count = ENTRY_COUNT_W'(n_count);
                end else if (r_addr == '0) begin
                    n_valid     = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = STS_NOT_FOUND;
                    n_out_count = ENTRY_COUNT_W'(r_count);
                end else begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend = 1'b0;
                if (match) begin
                    n_k   = r_pend_idx;
                    n_ent = r_rd_data;
                    case (r_op)
                        OP_QUERY: begin
                            n_valid     = 1'b1;
                            n_state     = S_IDLE;
                            n_status    = STS_OK;
                            n_avg       = r_rd_data.newest;
                            n_sig       = r_rd_data.level;
                            n_out_count = ENTRY_COUNT_W'(r_count);
                        end
                        OP_DELETE: begin
                            n_idx   = CNT_W'(r_pend_idx);
                            n_state = S_DEL;
                        end
                        default: begin
                            n_state = S_PREP;
                        end
                    endcase
                end else if (r_idx < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                    n_idx      = idx_plus;
                end else if (!r_pend) begin
                    n_valid     = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = STS_NOT_FOUND;
                    n_out_count = ENTRY_COUNT_W'(r_count);
                end
            end
            S_PREP: begin
                n_stale = (r_now - r_ent.last_seen) > TIME_W'(r_limit);
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum = SUM_W'($signed(r_sample)) + SUM_W'($signed(kept_mid))
                        + SUM_W'($signed(kept_old));
                n_state = S_ABS;
            end
            S_ABS: begin
                n_neg     = r_sum[SUM_W-1];
                n_mag     = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
                n_div_cnt = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (r_div_cnt == DSTEP_TRIPLE || r_div_cnt == DSTEP_REM) begin
                    n_sum = alu_res;
                end else begin
                    n_acc = alu_res;
                end
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DSTEP_FIX) begin
                    n_state = S_WRB;
                end
            end
            S_WRB: begin
                mem_we      = 1'b1;
                mem_waddr   = r_k;
                mem_wdata   = '{address: r_ent.address, newest: quot, middle: kept_mid,
                                oldest: kept_old, level: r_level, last_seen: r_now};
                n_valid     = 1'b1;
                n_state     = S_IDLE;
                n_status    = STS_OK;
                n_avg       = quot;
                n_sig       = r_level;
                n_clr       = r_stale;
                n_out_count = ENTRY_COUNT_W'(r_count);
            end
            S_DEL: begin
                rd_addr   = idx_plus[IDX_W-1:0];
                mem_waddr = r_pend_idx;
                mem_wdata = r_rd_data;
                mem_we    = r_pend;
                n_pend    = 1'b0;
                if (idx_plus < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                    n_idx      = idx_plus;
                end else if (!r_pend) begin
                    n_count     = r_count - CNT_W'(1);
                    n_valid     = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = STS_OK;
                    n_out_count = ENTRY_COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_entry_count     = r_out_count;
    assign o_range_average   = r_avg;
    assign o_signal_out      = r_sig;
    assign o_history_cleared = r_clr;

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result presented while a request is still in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_NOT_FOUND) |->
        (o_range_average == '0 && o_signal_out == '0 && !o_history_cleared))
        else $error("missed lookup returned nonzero data");

endmodule
